### src/compare_timer_peripheral_unit_macros.svh
// Assertion macros shared by the compare timer RTL.
`ifndef COMPARE_TIMER_PERIPHERAL_UNIT_MACROS_SVH
`define COMPARE_TIMER_PERIPHERAL_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// a holds at an edge -> b holds at the same edge
`define CTP_ASSERT_SAME(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("assertion failed: same-cycle implication");
// a holds at an edge -> b holds at the next edge
`define CTP_ASSERT_NEXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("assertion failed: next-cycle implication");
`else
`define CTP_ASSERT_SAME(label, a, b)
`define CTP_ASSERT_NEXT(label, a, b)
`endif

`endif

### src/ctp_pkg.sv
// Types and constants of the compare timer.
package ctp_pkg;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_WRITE = 2'd2;

  // word indices of the plain map
  localparam logic [3:0] IDX_CTRL   = 4'd0;
  localparam logic [3:0] IDX_IRQEN  = 4'd1;
  localparam logic [3:0] IDX_STATUS = 4'd2;
  localparam logic [3:0] IDX_COUNT  = 4'd3;
  localparam logic [3:0] IDX_CMP0   = 4'd4;
  localparam logic [3:0] IDX_CMP1   = 4'd5;
  // capture control word in the extended map
  localparam logic [3:0] IDX_CAPCTL = 4'd1;

  localparam logic [5:0] REGION_PLAIN = 6'd32;
  localparam logic [5:0] REGION_EXT   = 6'd48;

  localparam int CTRL_CLEAR_BIT      = 0;
  localparam int CTRL_ENABLE_BIT     = 1;
  localparam int CTRL_OVF_CMP1_BIT   = 13;
  localparam int CAPCTL_OVF_CMP1_BIT = 14;

  localparam logic [7:0] STAT_OVF  = 8'h01;
  localparam logic [7:0] STAT_CMP0 = 8'h02;
  localparam logic [7:0] STAT_CMP1 = 8'h04;

  typedef enum logic [2:0] {
    SEL_CTRL,
    SEL_IRQEN,
    SEL_STATUS,
    SEL_COUNT,
    SEL_CMP0,
    SEL_CMP1,
    SEL_CAPCTL,
    SEL_CAPTURE
  } reg_sel_t;

  typedef struct packed {
    logic [1:0]  operation;
    logic [5:0]  byte_offset;
    logic        word_access;
    logic [15:0] write_data;
  } req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        access_error;
    logic        irq;
  } res_t;

  // pipeline control between the input stage and the rest
  typedef struct packed {
    logic valid;
    logic adv;
  } stage_ctl_t;

endpackage

### src/ctp_in_stage.sv
// Input register of the compare timer.
module ctp_in_stage
  import ctp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  req_t       in_data,
  input  logic       adv,
  output logic       s1_valid,
  output req_t       s1_req
);

  logic s1_valid_r, s1_valid_nxt;
  req_t s1_req_r;
  logic take;

  assign in_stall     = s1_valid_r && !adv;
  assign take         = in_valid && !in_stall;
  assign s1_valid_nxt = take ? 1'b1 : (adv ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_req_r <= in_data;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_req   = s1_req_r;

endmodule

### src/ctp_core.sv
// Timer state, register decode and per-request update.
module ctp_core
  import ctp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       ext_layout,
  input  stage_ctl_t ctl,
  input  req_t       req,
  output res_t       res
);

  logic [15:0] ctrl_r, ctrl_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [15:0] cmp_r [2];
  logic [15:0] cmp_nxt [2];
  logic [15:0] capctl_r, capctl_nxt;
  logic [7:0]  irqen_r, irqen_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [7:0]  psc_r, psc_nxt;

  logic        fire;
  logic        wr;
  logic        bad;
  logic [3:0]  idx;
  logic [3:0]  midx;
  reg_sel_t    sel;
  logic        chg;
  logic        ovf_cmp1;
  logic [7:0]  psc_dec;
  logic [15:0] rd;
  logic        err;

  assign fire = ctl.valid && ctl.adv;
  assign wr   = (req.operation == OP_WRITE);
  assign idx  = req.byte_offset[5:2];
  assign midx = (ext_layout && idx > 4'd1) ? idx - 4'd1 : idx;
  assign bad  = (req.byte_offset[1:0] != 2'b00) || !req.word_access ||
                (req.byte_offset >= (ext_layout ? REGION_EXT : REGION_PLAIN));
  assign psc_dec = psc_r - 8'd1;

  always_comb begin
    if (ext_layout && idx == IDX_CAPCTL) begin
      sel = SEL_CAPCTL;
    end else begin
      unique case (midx)
        IDX_CTRL:   sel = SEL_CTRL;
        IDX_IRQEN:  sel = SEL_IRQEN;
        IDX_STATUS: sel = SEL_STATUS;
        IDX_COUNT:  sel = SEL_COUNT;
        IDX_CMP0:   sel = SEL_CMP0;
        IDX_CMP1:   sel = SEL_CMP1;
        default:    sel = SEL_CAPTURE;
      endcase
    end
  end

  always_comb begin
    ctrl_nxt   = ctrl_r;
    cnt_nxt    = cnt_r;
    cmp_nxt[0] = cmp_r[0];
    cmp_nxt[1] = cmp_r[1];
    capctl_nxt = capctl_r;
    irqen_nxt  = irqen_r;
    status_nxt = status_r;
    psc_nxt    = psc_r;
    rd         = '0;
    err        = 1'b0;
    chg        = 1'b0;
    ovf_cmp1   = 1'b0;

    if (fire) begin
      case (req.operation) inside
        OP_TICK: begin
          if (ctrl_r[CTRL_ENABLE_BIT]) begin
            if (psc_dec == 8'd0) begin
              psc_nxt = 8'd1 << ctrl_r[4:2];
              cnt_nxt = cnt_r + 16'd1;
              chg     = 1'b1;
            end else begin
              psc_nxt = psc_dec;
            end
          end
        end
        OP_READ, OP_WRITE: begin
          if (bad) begin
            err = 1'b1;
          end else begin
            unique case (sel)
              SEL_CTRL: begin
                if (wr) begin
                  ctrl_nxt = req.write_data & 16'hFFFE;
                  if (req.write_data[CTRL_CLEAR_BIT]) begin
                    cnt_nxt = '0;
                    chg     = 1'b1;
                  end
                end else begin
                  rd = ctrl_r;
                end
              end
              SEL_IRQEN: begin
                if (wr) irqen_nxt = req.write_data[7:0];
                else    rd = {8'd0, irqen_r};
              end
              SEL_STATUS: begin
                if (wr) status_nxt = status_r & ~req.write_data[7:0];
                else    rd = {8'd0, status_r};
              end
              SEL_COUNT: begin
                if (wr) begin
                  cnt_nxt = req.write_data;
                  chg     = 1'b1;
                end else begin
                  rd = cnt_r;
                end
              end
              SEL_CMP0: begin
                if (wr) cmp_nxt[0] = req.write_data;
                else    rd = cmp_r[0];
              end
              SEL_CMP1: begin
                if (wr) cmp_nxt[1] = req.write_data;
                else    rd = cmp_r[1];
              end
              SEL_CAPCTL: begin
                if (wr) capctl_nxt = req.write_data;
                else    rd = capctl_r;
              end
              default: begin
                // capture words read zero and refuse writes
                err = wr;
              end
            endcase
          end
        end
        default: ;
      endcase
    end

    // compares see the old count, zero overflow the new; control as written
    if (chg) begin
      ovf_cmp1 = ext_layout ? capctl_nxt[CAPCTL_OVF_CMP1_BIT]
                            : ctrl_nxt[CTRL_OVF_CMP1_BIT];
      if (cnt_r == cmp_r[0]) status_nxt = status_nxt | STAT_CMP0;
      if (cnt_r == cmp_r[1]) status_nxt = status_nxt | STAT_CMP1;
      if (ovf_cmp1) begin
        if (cnt_r == cmp_r[1]) begin
          cnt_nxt    = '0;
          status_nxt = status_nxt | STAT_OVF;
        end
      end else if (cnt_nxt == 16'd0) begin
        status_nxt = status_nxt | STAT_OVF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r   <= '0;
      cnt_r    <= '0;
      cmp_r[0] <= 16'hFFFF;
      cmp_r[1] <= 16'hFFFF;
      capctl_r <= '0;
      irqen_r  <= '0;
      status_r <= '0;
      psc_r    <= '0;
    end else begin
      ctrl_r   <= ctrl_nxt;
      cnt_r    <= cnt_nxt;
      cmp_r[0] <= cmp_nxt[0];
      cmp_r[1] <= cmp_nxt[1];
      capctl_r <= capctl_nxt;
      irqen_r  <= irqen_nxt;
      status_r <= status_nxt;
      psc_r    <= psc_nxt;
    end
  end

  assign res.read_data    = (wr || err) ? 16'd0 : rd;
  assign res.access_error = err;
  assign res.irq          = |(status_nxt & irqen_nxt);

endmodule

### src/compare_timer_peripheral_unit.sv
// Top level of the compare timer: input stage, timer core, result register.
//
// Usage notes:
//  - Request channel (in_valid / in_stall / in_data): one request is a
//    prescaler tick, a register read or a register write. A request is taken
//    on a rising edge with in_valid high and in_stall low.
//  - Result channel (out_valid / out_stall / out_data): exactly one result per
//    request, in order: read data, access error flag and the irq level after
//    the request has been applied.
//  - Config channel (cfg_valid / cfg_ready / cfg_data): selects the extended
//    register map. cfg_ready is always high; write only while idle.
//  - Path: a request passes the input register, then the result register, before
//    out_valid rises for it. Throughput: one request per cycle while out_stall
//    holds no pending result, set by the single pass through the core's decode
//    and compare logic.
//  - Reset (rst_n low, synchronous): both pipeline stages empty, control,
//    counter, enables, status and prescaler zero, compares all ones, plain map.
//  - While out_stall holds a pending result, the result register keeps its
//    value and in_stall rises once the input register holds its one request.
`include "compare_timer_peripheral_unit_macros.svh"

module compare_timer_peripheral_unit
  import ctp_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic cfg_data
);

  logic       ext_layout_r;
  logic       out_valid_r, out_valid_nxt;
  res_t       out_data_r;
  logic       adv;
  logic       s1_valid;
  req_t       s1_req;
  stage_ctl_t ctl;
  res_t       core_res;

  // result register frees up when empty or being taken
  assign adv = !out_valid_r || !out_stall;

  assign cfg_ready = 1'b1;

  ctp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_req   (s1_req)
  );

  assign ctl.valid = s1_valid;
  assign ctl.adv   = adv;

  ctp_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .ext_layout (ext_layout_r),
    .ctl        (ctl),
    .req        (s1_req),
    .res        (core_res)
  );

  assign out_valid_nxt = adv ? s1_valid : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      ext_layout_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        ext_layout_r <= cfg_data;
      end
    end
  end

  // payload held while stalled
  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      out_data_r <= core_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // input side only backs up behind a full result register
  `CTP_ASSERT_SAME(a_stall_needs_full_out, in_stall, out_valid_r && out_stall)
  // a request leaving the input register shows up as a result next cycle
  `CTP_ASSERT_NEXT(a_stage_to_out, s1_valid && adv, out_valid_r)
  // rejected accesses return no data
  `CTP_ASSERT_SAME(a_err_zero_data, out_valid_r && out_data_r.access_error,
                   out_data_r.read_data == 16'd0)

endmodule

### tb/tb.sv
// Self-checking testbench for the compare timer peripheral unit.
`timescale 1ns / 100ps

module tb;
  import ctp_pkg::*;

  // Request code with no meaning: the block must ignore it.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  res_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_data;

  // Timer state as the block should hold it.
  logic        map_ext;
  logic [15:0] timer_ctrl;
  logic [15:0] timer_count;
  logic [15:0] cmp_val [2];
  logic [15:0] cap_ctrl;
  logic [7:0]  irq_en;
  logic [7:0]  stat_bits;
  logic [7:0]  presc;

  res_t pending_results [$];
  int   mismatch_count = 0;
  int   cycle_count = 0;
  int   stall_hold = 0;   // receiver hold-off, in cycles
  bit   idle_on = 1'b1;   // random idling on both sides

  compare_timer_peripheral_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Timer behaviour
  // ---------------------------------------------------------------------------

  // Any change of the counter looks at its previous value: compare hits set
  // their status bits, then overflow comes either from a compare-one hit
  // (which also zeroes the counter) or from the counter sitting at zero.
  function automatic void count_changed(logic [15:0] prev);
    logic ovf_cmp1;
    ovf_cmp1 = map_ext ? cap_ctrl[CAPCTL_OVF_CMP1_BIT] : timer_ctrl[CTRL_OVF_CMP1_BIT];
    if (prev == cmp_val[0]) stat_bits |= STAT_CMP0;
    if (prev == cmp_val[1]) stat_bits |= STAT_CMP1;
    if (ovf_cmp1) begin
      if (prev == cmp_val[1]) begin
        timer_count = '0;
        stat_bits |= STAT_OVF;
      end
    end else if (timer_count == 16'd0) begin
      stat_bits |= STAT_OVF;
    end
  endfunction

  // Applies one request to the timer state and returns the result it gives.
  function automatic res_t timer_response(req_t r);
    res_t        res;
    logic [5:0]  region;
    logic [3:0]  idx;
    logic        wr;
    logic [15:0] prev;
    logic [15:0] d;
    res = '0;
    wr = (r.operation == OP_WRITE);
    d = r.write_data;
    if (r.operation == OP_TICK) begin
      if (timer_ctrl[CTRL_ENABLE_BIT]) begin
        presc = presc - 8'd1;
        if (presc == 8'd0) begin
          prev = timer_count;
          presc = 8'd1 << timer_ctrl[4:2];
          timer_count = timer_count + 16'd1;
          count_changed(prev);
        end
      end
    end else if (r.operation == OP_READ || wr) begin
      region = map_ext ? REGION_EXT : REGION_PLAIN;
      idx = r.byte_offset[5:2];
      if (r.byte_offset[1:0] != 2'b00 || !r.word_access || r.byte_offset >= region) begin
        res.access_error = 1'b1;
      end else if (map_ext && idx == IDX_CAPCTL) begin
        if (wr) cap_ctrl = d; else res.read_data = cap_ctrl;
      end else begin
        // the extended map pushes everything after the capture control up a word
        if (map_ext && idx > IDX_CAPCTL) idx = idx - 4'd1;
        case (idx) inside
          IDX_CTRL: begin
            if (wr) begin
              timer_ctrl = d & ~(16'd1 << CTRL_CLEAR_BIT);
              if (d[CTRL_CLEAR_BIT]) begin
                prev = timer_count;
                timer_count = '0;
                count_changed(prev);
              end
            end else begin
              res.read_data = timer_ctrl;
            end
          end
          IDX_IRQEN: begin
            if (wr) irq_en = d[7:0]; else res.read_data = {8'h00, irq_en};
          end
          IDX_STATUS: begin
            // write one to clear
            if (wr) stat_bits = stat_bits & ~d[7:0]; else res.read_data = {8'h00, stat_bits};
          end
          IDX_COUNT: begin
            if (wr) begin
              prev = timer_count;
              timer_count = d;
              count_changed(prev);
            end else begin
              res.read_data = timer_count;
            end
          end
          IDX_CMP0, IDX_CMP1: begin
            if (wr) cmp_val[idx == IDX_CMP1] = d;
            else res.read_data = cmp_val[idx == IDX_CMP1];
          end
          default: begin
            // capture registers read zero and refuse writes
            res.access_error = wr;
          end
        endcase
      end
    end
    res.irq = |(stat_bits & irq_en);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  function automatic req_t bus_req(logic [1:0] op, logic [5:0] off, logic word,
                                   logic [15:0] data);
    req_t r;
    r.operation = op;
    r.byte_offset = off;
    r.word_access = word;
    r.write_data = data;
    return r;
  endfunction

  // Drops valid at the next falling edge; anything that is not a further
  // request must start with this, or the last request would be taken twice.
  task automatic idle_input();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // Offers one request, with an optional random gap first, and records the
  // expected result once the block takes it.
  task automatic send_req(req_t r);
    if (idle_on && $urandom_range(0, 99) < 31) begin
      repeat ($urandom_range(1, 3)) idle_input();
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(timer_response(r));
  endtask

  task automatic wait_drained();
    idle_input();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Layout select: only written with the pipeline empty.
  task automatic set_layout(logic ext);
    wait_drained();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= ext;
    do @(posedge clk); while (!cfg_ready);
    map_ext = ext;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Counter and compare values: half close to the live count so that
  // compare hits happen, a quarter at the top so the counter wraps.
  function automatic logic [15:0] near_count();
    int k;
    k = $urandom_range(0, 99);
    if (k < 25) return 16'($urandom());
    if (k < 50) return 16'hFFF8 + 16'($urandom_range(0, 7));
    return timer_count + 16'($urandom_range(0, 8));
  endfunction

  function automatic req_t random_req();
    req_t       r;
    int         k;
    logic [3:0] idx;
    logic [5:0] region;
    region = map_ext ? REGION_EXT : REGION_PLAIN;
    k = $urandom_range(0, 99);
    if (k < 45) r.operation = OP_TICK;
    else if (k < 70) r.operation = OP_READ;
    else if (k < 96) r.operation = OP_WRITE;
    else r.operation = OP_UNUSED;
    if ($urandom_range(0, 99) < 85) begin
      r.word_access = 1'b1;
      r.byte_offset = {4'($urandom_range(0, region / 4 - 1)), 2'b00};
    end else begin
      r.word_access = 1'($urandom_range(0, 1));
      r.byte_offset = 6'($urandom_range(0, 63));
    end
    r.write_data = 16'($urandom());
    idx = r.byte_offset[5:2];
    if (map_ext && idx == IDX_CAPCTL) begin
      return r;
    end
    if (map_ext && idx > IDX_CAPCTL) idx = idx - 4'd1;
    if (idx == IDX_CTRL && $urandom_range(0, 99) < 80) begin
      // a sane control word: running, short reload, sometimes compare-one mode
      r.write_data = '0;
      r.write_data[CTRL_ENABLE_BIT] = ($urandom_range(0, 9) != 0);
      r.write_data[CTRL_CLEAR_BIT] = ($urandom_range(0, 9) == 0);
      r.write_data[4:2] = 3'($urandom_range(0, 2));
      r.write_data[CTRL_OVF_CMP1_BIT] = ($urandom_range(0, 3) == 0);
    end else if (idx == IDX_COUNT || idx == IDX_CMP0 || idx == IDX_CMP1) begin
      r.write_data = near_count();
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side
  // ---------------------------------------------------------------------------

  // Receiver: a counted hold-off when asked for, else random stalls if idling is on.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_hold > 0) begin
        out_stall <= 1'b1;
        stall_hold = stall_hold - 1;
      end else begin
        out_stall <= idle_on && ($urandom_range(0, 99) < 31);
      end
    end
  end

  // Each result taken is checked against the oldest expectation.
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: rd=%h err=%b irq=%b",
                   out_data.read_data, out_data.access_error, out_data.irq);
      end else begin
        want = pending_results.pop_front();
        if (out_data.read_data !== want.read_data ||
            out_data.access_error !== want.access_error ||
            out_data.irq !== want.irq) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("result mismatch: expected rd=%h err=%b irq=%b, got rd=%h err=%b irq=%b",
                     want.read_data, want.access_error, want.irq,
                     out_data.read_data, out_data.access_error, out_data.irq);
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every register of the plain map straight after reset, captures included.
  task automatic test_reset_values();
    for (int a = 0; a < 32; a += 4) send_req(bus_req(OP_READ, 6'(a), 1'b1, 16'h0000));
  endtask

  // Rejected accesses and the unused request code leave state alone.
  task automatic test_bad_access();
    send_req(bus_req(OP_READ, 6'h20, 1'b1, 16'h0000));    // beyond the plain region
    send_req(bus_req(OP_READ, 6'h02, 1'b1, 16'h0000));    // misaligned
    send_req(bus_req(OP_WRITE, 6'h00, 1'b0, 16'hFFFF));   // not a word access
    send_req(bus_req(OP_WRITE, 6'h1C, 1'b1, 16'hFFFF));   // capture write
    send_req(bus_req(OP_WRITE, 6'h3C, 1'b1, 16'hFFFF));   // top of the offset range
    send_req(bus_req(OP_UNUSED, 6'h3F, 1'b1, 16'hFFFF));
    send_req(bus_req(OP_READ, 6'h00, 1'b1, 16'h0000));
  endtask

  // Compare hits, overflow on zero, compare-one overflow, status clear.
  task automatic test_compare_paths();
    send_req(bus_req(OP_WRITE, 6'h04, 1'b1, 16'hFFFF));  // only 8 enable bits kept
    send_req(bus_req(OP_WRITE, 6'h10, 1'b1, 16'h0005));
    send_req(bus_req(OP_WRITE, 6'h0C, 1'b1, 16'h0005));
    send_req(bus_req(OP_WRITE, 6'h0C, 1'b1, 16'h0000));  // compare zero hit, zero overflow
    send_req(bus_req(OP_READ, 6'h08, 1'b1, 16'h0000));
    send_req(bus_req(OP_WRITE, 6'h08, 1'b1, 16'hFFFF));
    send_req(bus_req(OP_WRITE, 6'h00, 1'b1, 16'h2001));  // compare-one mode plus clear
    send_req(bus_req(OP_WRITE, 6'h14, 1'b1, 16'h0007));
    send_req(bus_req(OP_WRITE, 6'h0C, 1'b1, 16'h0007));
    send_req(bus_req(OP_WRITE, 6'h0C, 1'b1, 16'h1234));  // hit on compare one clears count
    send_req(bus_req(OP_READ, 6'h0C, 1'b1, 16'h0000));
    send_req(bus_req(OP_READ, 6'h08, 1'b1, 16'h0000));
  endtask

  // Extended map: capture control word and the shifted registers.
  task automatic test_extended_map();
    send_req(bus_req(OP_READ, 6'h04, 1'b1, 16'h0000));
    send_req(bus_req(OP_WRITE, 6'h04, 1'b1, 16'hFFFF));
    send_req(bus_req(OP_READ, 6'h08, 1'b1, 16'h0000));
    send_req(bus_req(OP_READ, 6'h2C, 1'b1, 16'h0000));
    send_req(bus_req(OP_WRITE, 6'h2C, 1'b1, 16'h0000));
    send_req(bus_req(OP_READ, 6'h30, 1'b1, 16'h0000));
  endtask

  task automatic test_random_traffic(int n);
    repeat (n) send_req(random_req());
  endtask

  // The receiver holds off long enough for the block to fill and stall its
  // input while requests keep coming; then the sender waits for the drain.
  task automatic test_backpressure();
    idle_on = 1'b0;
    stall_hold = 80;
    repeat (24) send_req(random_req());
    wait_drained();
    idle_on = 1'b1;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = 1'b0;
    map_ext = 1'b0;
    timer_ctrl = '0;
    timer_count = '0;
    cmp_val[0] = 16'hFFFF;
    cmp_val[1] = 16'hFFFF;
    cap_ctrl = '0;
    irq_en = '0;
    stat_bits = '0;
    presc = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    set_layout(1'b0);
    test_reset_values();
    test_bad_access();
    test_compare_paths();
    set_layout(1'b1);
    test_extended_map();
    set_layout(1'b0);
    test_random_traffic(300);
    test_backpressure();
    set_layout(1'b1);
    idle_on = 1'b0;
    test_random_traffic(200);
    idle_on = 1'b1;
    test_random_traffic(150);
    set_layout(1'b0);
    test_random_traffic(250);
    set_layout(1'b1);
    test_random_traffic(300);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/ctp_pkg.sv
src/ctp_in_stage.sv
src/ctp_core.sv
src/compare_timer_peripheral_unit.sv
tb/tb.sv
